// ----- hdl/jtok_pkg.sv -----
// Shared token codes and result/queue entry types for the JSON tokenizer.
`timescale 1ns / 1ps

package jtok_pkg;

  typedef enum logic [3:0] {
    TK_LBRACE    = 4'd0,
    TK_RBRACE    = 4'd1,
    TK_LBRACKET  = 4'd2,
    TK_RBRACKET  = 4'd3,
    TK_COMMA     = 4'd4,
    TK_COLON     = 4'd5,
    TK_NUMBER    = 4'd6,
    TK_STR_START = 4'd7,
    TK_STR_BYTE  = 4'd8,
    TK_STR_END   = 4'd9,
    TK_TRUE      = 4'd10,
    TK_FALSE     = 4'd11,
    TK_NULL      = 4'd12,
    TK_ERROR     = 4'd13
  } token_kind_t;

  localparam int VALUE_W = 32;

  typedef struct packed {
    token_kind_t        kind;
    logic [VALUE_W-1:0] number_value;
    logic [7:0]         string_byte;
    logic               error_code;
  } result_t;

  // One request through the queue: the results caused by one input byte.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } entry_t;

endpackage

// ----- hdl/jtok_front.sv -----
// Front end: accepts text bytes, runs the lexer state and forms queue entries.
`timescale 1ns / 1ps

module jtok_front #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          ch,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  logic                q_full,
  output logic                q_push,
  output jtok_pkg::entry_t    q_entry
);

  localparam logic ERR_EOF  = 1'b0;
  localparam logic ERR_CHAR = 1'b1;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_NUMBER  = 3'd1,
    M_STRING  = 3'd2,
    M_ESCAPE  = 3'd3,
    M_KEYWORD = 3'd4,
    M_DEAD    = 3'd5
  } mode_t;

  // Outcome of treating a byte as the start of a new token.
  typedef struct packed {
    logic              emit;
    jtok_pkg::result_t res;
    mode_t             mode;
    logic              set_kw;
    logic [1:0]        kw_id;
    logic              set_num;
    logic              neg;
    logic [3:0]        digit;
  } fresh_t;

  function automatic jtok_pkg::result_t tok(jtok_pkg::token_kind_t k);
    jtok_pkg::result_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic jtok_pkg::result_t err_tok(logic code);
    jtok_pkg::result_t r;
    r = '0;
    r.kind = jtok_pkg::TK_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic logic [7:0] kw_char(logic [1:0] id, logic [2:0] pos);
    logic [7:0] c;
    unique case ({id, pos})
      {2'd0, 3'd1}: c = "r";
      {2'd0, 3'd2}: c = "u";
      {2'd0, 3'd3}: c = "e";
      {2'd1, 3'd1}: c = "a";
      {2'd1, 3'd2}: c = "l";
      {2'd1, 3'd3}: c = "s";
      {2'd1, 3'd4}: c = "e";
      {2'd2, 3'd1}: c = "u";
      {2'd2, 3'd2}: c = "l";
      {2'd2, 3'd3}: c = "l";
      default:      c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] kw_len(logic [1:0] id);
    logic [2:0] n;
    unique case (id)
      2'd0:    n = 3'd4;
      2'd1:    n = 3'd5;
      2'd2:    n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic fresh_t fresh_tok(logic [7:0] c);
    fresh_t f;
    f = '0;
    f.mode = M_IDLE;
    unique case (c)
      8'h00: begin
        f.emit = 1'b1;
        f.res  = err_tok(ERR_EOF);
        f.mode = M_DEAD;
      end
      8'h20, 8'h09, 8'h0D, 8'h0A, 8'h0B: f.mode = M_IDLE;
      "{": begin f.emit = 1'b1; f.res = tok(jtok_pkg::TK_LBRACE);   end
      "}": begin f.emit = 1'b1; f.res = tok(jtok_pkg::TK_RBRACE);   end
      "[": begin f.emit = 1'b1; f.res = tok(jtok_pkg::TK_LBRACKET); end
      "]": begin f.emit = 1'b1; f.res = tok(jtok_pkg::TK_RBRACKET); end
      ",": begin f.emit = 1'b1; f.res = tok(jtok_pkg::TK_COMMA);    end
      ":": begin f.emit = 1'b1; f.res = tok(jtok_pkg::TK_COLON);    end
      "\"": begin
        f.emit = 1'b1;
        f.res  = tok(jtok_pkg::TK_STR_START);
        f.mode = M_STRING;
      end
      "t": begin f.set_kw = 1'b1; f.kw_id = 2'd0; f.mode = M_KEYWORD; end
      "f": begin f.set_kw = 1'b1; f.kw_id = 2'd1; f.mode = M_KEYWORD; end
      "n": begin f.set_kw = 1'b1; f.kw_id = 2'd2; f.mode = M_KEYWORD; end
      "-": begin
        f.set_num = 1'b1;
        f.neg     = 1'b1;
        f.mode    = M_NUMBER;
      end
      default: begin
        if (c >= "0" && c <= "9") begin
          f.set_num = 1'b1;
          f.digit   = c[3:0];
          f.mode    = M_NUMBER;
        end else begin
          f.emit = 1'b1;
          f.res  = err_tok(ERR_CHAR);
          f.mode = M_DEAD;
        end
      end
    endcase
    return f;
  endfunction

  mode_t                   mode, mode_next;
  logic [NUMBER_WIDTH-1:0] acc, acc_next;
  logic                    neg, neg_next;
  logic [1:0]              kw_id, kw_id_next;
  logic [2:0]              kw_pos, kw_pos_next;

  fresh_t                  f;
  logic                    accept;
  logic                    is_digit;
  logic [NUMBER_WIDTH-1:0] acc_x10;
  logic [NUMBER_WIDTH-1:0] num_val;
  logic [2:0]              kw_pos_inc;
  logic                    kw_match;
  logic                    use_fresh;
  logic                    after_num;
  logic [1:0]              n;
  jtok_pkg::result_t       r0, r1;

  assign accept   = byte_valid && !q_full;
  assign f        = fresh_tok(ch);
  assign is_digit = (ch >= "0") && (ch <= "9");
  assign acc_x10  = (acc << 3) + (acc << 1);
  assign num_val  = neg ? ('0 - acc) : acc;

  assign kw_pos_inc = kw_pos + 3'd1;
  assign kw_match   = (kw_id != 2'd3) && (kw_pos < kw_len(kw_id)) &&
                      (ch == kw_char(kw_id, kw_pos));

  always_comb begin
    mode_next   = mode;
    acc_next    = acc;
    neg_next    = neg;
    kw_id_next  = kw_id;
    kw_pos_next = kw_pos;
    r0          = '0;
    r1          = '0;
    n           = 2'd0;
    use_fresh   = 1'b0;
    after_num   = 1'b0;
    unique case (mode)
      M_IDLE: use_fresh = 1'b1;
      M_NUMBER: begin
        if (ch == 8'h00) begin
          r0        = err_tok(ERR_EOF);
          n         = 2'd1;
          mode_next = M_DEAD;
        end else if (is_digit) begin
          acc_next = acc_x10 + NUMBER_WIDTH'(ch[3:0]);
        end else begin
          // number ends; the same byte then starts a new token
          r0              = tok(jtok_pkg::TK_NUMBER);
          r0.number_value = jtok_pkg::VALUE_W'(signed'(num_val));
          n               = 2'd1;
          mode_next       = M_IDLE;
          after_num       = 1'b1;
          use_fresh       = 1'b1;
        end
      end
      M_STRING: begin
        if (ch == 8'h00) begin
          r0        = err_tok(ERR_EOF);
          n         = 2'd1;
          mode_next = M_DEAD;
        end else if (ch == "\\") begin
          mode_next = M_ESCAPE;
        end else if (ch == "\"") begin
          r0        = tok(jtok_pkg::TK_STR_END);
          n         = 2'd1;
          mode_next = M_IDLE;
        end else begin
          r0             = tok(jtok_pkg::TK_STR_BYTE);
          r0.string_byte = ch;
          n              = 2'd1;
        end
      end
      M_ESCAPE: begin
        if (ch == 8'h00) begin
          r0        = err_tok(ERR_EOF);
          n         = 2'd1;
          mode_next = M_DEAD;
        end else begin
          mode_next      = M_STRING;
          r0             = tok(jtok_pkg::TK_STR_BYTE);
          n              = 2'd1;
          unique case (ch)
            "\"", "\\", "/": r0.string_byte = ch;
            "b":             r0.string_byte = 8'h08;
            "f":             r0.string_byte = 8'h0C;
            "n":             r0.string_byte = 8'h0A;
            "r":             r0.string_byte = 8'h0D;
            "t":             r0.string_byte = 8'h09;
            default: begin
              // unknown escape: byte dropped
              r0 = '0;
              n  = 2'd0;
            end
          endcase
        end
      end
      M_KEYWORD: begin
        if (ch == 8'h00) begin
          r0        = err_tok(ERR_EOF);
          n         = 2'd1;
          mode_next = M_DEAD;
        end else if (kw_match) begin
          kw_pos_next = kw_pos_inc;
          if (kw_pos_inc == kw_len(kw_id)) begin
            r0        = tok(jtok_pkg::token_kind_t'(4'(jtok_pkg::TK_TRUE) + 4'(kw_id)));
            n         = 2'd1;
            mode_next = M_IDLE;
          end
        end else begin
          r0        = err_tok(ERR_CHAR);
          n         = 2'd1;
          mode_next = M_DEAD;
        end
      end
      default: begin
        // error seen (or unused code): silent until reset
      end
    endcase

    if (use_fresh) begin
      mode_next = f.mode;
      if (f.set_kw) begin
        kw_id_next  = f.kw_id;
        kw_pos_next = 3'd1;
      end
      if (f.set_num) begin
        neg_next = f.neg;
        acc_next = NUMBER_WIDTH'(f.digit);
      end
      if (f.emit) begin
        if (after_num) begin
          r1 = f.res;
        end else begin
          r0 = f.res;
        end
        n = n + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      acc    <= '0;
      neg    <= 1'b0;
      kw_id  <= 2'd0;
      kw_pos <= 3'd0;
    end else if (accept) begin
      mode   <= mode_next;
      acc    <= acc_next;
      neg    <= neg_next;
      kw_id  <= kw_id_next;
      kw_pos <= kw_pos_next;
    end
  end

  assign byte_stall     = q_full;
  assign q_push         = accept && (n != 2'd0);
  assign q_entry.two    = (n == 2'd2);
  assign q_entry.first  = r0;
  assign q_entry.second = r1;

endmodule

// ----- hdl/jtok_queue.sv -----
// Short FIFO of per-byte result requests between front and back end.
`timescale 1ns / 1ps

module jtok_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jtok_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output jtok_pkg::entry_t head
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  jtok_pkg::entry_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

endmodule

// ----- hdl/jtok_back.sv -----
// Back end: splits queued requests into single tokens in the output register.
`timescale 1ns / 1ps

module jtok_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  jtok_pkg::entry_t  head,
  output logic              pop,
  output logic              token_valid,
  input  logic              token_stall,
  output jtok_pkg::result_t res,
  output logic              last
);

  logic second_half;
  logic load;

  assign load = !empty && (!token_valid || !token_stall);
  assign pop  = load && (!head.two || second_half);

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
      second_half <= 1'b0;
    end else if (load) begin
      token_valid <= 1'b1;
      second_half <= head.two && !second_half;
    end else if (!token_stall) begin
      token_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res  <= second_half ? head.second : head.first;
      last <= !head.two || second_half;
    end
  end

endmodule

// ----- hdl/json_tokenizer.sv -----
// Top level of the integer-only JSON tokenizer: front end, request queue, back end.
// A byte's request is written into the queue; its tokens then load into the output register.
// Throughput: one byte per cycle in while byte_stall is low, one token per cycle out while
//   token_stall is low; a byte that ends a number and starts a new token yields two tokens.
// The 4-entry request queue absorbs such bursts; byte_stall rises only when it is full.
// Reset (rst, synchronous): lexer back to idle, queue emptied, output register invalid.
`timescale 1ns / 1ps

module json_tokenizer #(
  parameter int NUMBER_WIDTH = 32  // integer accumulator width, 8 to 64; wraps at this width
) (
  input  logic               clk,
  input  logic               rst,
  // text byte channel
  input  logic [7:0]         ch,
  input  logic               byte_valid,
  output logic               byte_stall,
  // token channel
  output logic [3:0]         token_kind,
  output logic signed [31:0] number_value,
  output logic [7:0]         string_byte,
  output logic               error_code,
  output logic               last,
  output logic               token_valid,
  input  logic               token_stall
);

  // Front end -> queue: one request per byte that causes any token.
  logic              q_push;
  logic              q_full;
  jtok_pkg::entry_t  q_entry;

  // Queue -> back end.
  logic              q_pop;
  logic              q_empty;
  jtok_pkg::entry_t  q_head;

  jtok_pkg::result_t out_res;

  // Lexer state lives here; whitespace outside a number, keyword letters but the last,
  // digits and escape prefixes update state without producing a request.
  jtok_front #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .ch         (ch),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  jtok_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // Back end holds the output register, so a waiting token does not
  // block the front end from taking more bytes until the queue is full.
  jtok_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (q_empty),
    .head        (q_head),
    .pop         (q_pop),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .res         (out_res),
    .last        (last)
  );

  assign token_kind   = out_res.kind;
  assign number_value = out_res.number_value;
  assign string_byte  = out_res.string_byte;
  assign error_code   = out_res.error_code;

`ifndef SYNTHESIS
  // The front end never pushes into a full queue.
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("request pushed into full queue");

  // A two-token request always starts with the number that a non-digit ended.
  assert property (@(posedge clk) disable iff (rst)
    (q_push && q_entry.two) |-> (q_entry.first.kind == jtok_pkg::TK_NUMBER))
    else $error("two-token request does not start with a number");

  // Once the first of two tokens is taken, the second follows without a gap.
  assert property (@(posedge clk) disable iff (rst)
    (token_valid && !token_stall && !last) |=> token_valid)
    else $error("second token of a byte not presented next cycle");
`endif

endmodule
